// ===== hdl/swpm_pkg.sv =====
package swpm_pkg;

  typedef enum logic [2:0] {
    CFG_ENABLE = 3'd0,
    CFG_MONO   = 3'd1,
    CFG_MIX    = 3'd2,
    CFG_WIDTH  = 3'd3,
    CFG_PAN    = 3'd4
  } cfg_idx_e;

  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 8;
  localparam int MIX_W        = 7;
  localparam int WIDTH_W      = 8;
  localparam int PAN_W        = 8;
  localparam int PCT_FULL     = 100;
  localparam int WIDTH_MAX    = 200;
  localparam int GAIN_ENTRIES = 101;
  localparam int GAIN_IDX_W   = 7;
  localparam int GUARD_BITS   = 4;

  // Bias and shift that turn both rounded divisions into a floor division by 25.
  localparam int U_BIAS    = 12;
  localparam int MIX_SHIFT = 2;

  localparam int DIV_LANES       = 2;
  localparam int DIG_BITS        = 4;
  localparam int STEPS_PER_STAGE = 3;
  localparam int DIVISOR         = 25;
  localparam int REM_W           = 5;
  localparam int STEP_W          = REM_W + DIG_BITS;
  localparam int RECIP_W         = 12;
  localparam int STEP_PROD_W     = STEP_W + RECIP_W;
  localparam int DIV_RECIP       = 2622;
  localparam int DIV_RECIP_SHIFT = 16;

  typedef struct packed {
    logic [DIG_BITS-1:0] dig;
    logic [REM_W-1:0]    rem;
  } div_step_t;

  // One radix-16 digit of a division by 25; the remainder stays below 25.
  function automatic div_step_t div_step(logic [REM_W-1:0] rem, logic [DIG_BITS-1:0] chunk);
    logic [STEP_W-1:0]      v;
    logic [STEP_PROD_W-1:0] prod;
    div_step_t              r;
    v     = {rem, chunk};
    prod  = STEP_PROD_W'(v) * STEP_PROD_W'(DIV_RECIP);
    r.dig = prod[DIV_RECIP_SHIFT +: DIG_BITS];
    r.rem = REM_W'(v - STEP_W'(r.dig) * STEP_W'(DIVISOR));
    return r;
  endfunction

  // Gain table entry k: round(sqrt(k/100) * 2^frac), evaluated at elaboration.
  function automatic logic [63:0] gain_entry(int k, int frac);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bit_v;
    v     = (64'(k) << (2 * frac + 2)) / 64'd100;
    res   = '0;
    bit_v = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (v >= res + bit_v) begin
        v   = v - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return (res + 64'd1) >> 1;
  endfunction

endpackage

// ===== hdl/swpm_div25.sv =====
module swpm_div25 import swpm_pkg::*; #(
  parameter int IN_W   = 34,
  parameter int SIDE_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [IN_W-1:0]   in_num_i [DIV_LANES],
  input  logic [SIDE_W-1:0] in_side_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [IN_W-1:0]   out_quo_o [DIV_LANES],
  output logic [SIDE_W-1:0] out_side_o
);

  localparam int NRAW = (IN_W + DIG_BITS - 1) / DIG_BITS;
  localparam int NST  = (NRAW + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
  localparam int NDIG = NST * STEPS_PER_STAGE;
  localparam int DW   = NDIG * DIG_BITS;

  logic [DW-1:0]     word_q [NST][DIV_LANES];
  logic [REM_W-1:0]  rem_q  [NST][DIV_LANES];
  logic [SIDE_W-1:0] side_q [NST];
  logic [NST-1:0]    vld_q;
  logic [NST-1:0]    rdy;

  for (genvar s = 0; s < NST; s++) begin : g_stage
    logic [DW-1:0]     word_in [DIV_LANES];
    logic [DW-1:0]     word_d  [DIV_LANES];
    logic [REM_W-1:0]  rem_in  [DIV_LANES];
    logic [REM_W-1:0]  rem_d   [DIV_LANES];
    logic [SIDE_W-1:0] side_in;
    logic              vld_in;

    if (s == 0) begin : g_first
      for (genvar l = 0; l < DIV_LANES; l++) begin : g_lane
        assign word_in[l] = DW'(in_num_i[l]);
        assign rem_in[l]  = '0;
      end
      assign side_in = in_side_i;
      assign vld_in  = in_valid_i;
    end else begin : g_next
      assign word_in = word_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign side_in = side_q[s-1];
      assign vld_in  = vld_q[s-1];
    end

    if (s == NST - 1) begin : g_rdy_last
      assign rdy[s] = !vld_q[s] || out_ready_i;
    end else begin : g_rdy_mid
      assign rdy[s] = !vld_q[s] || rdy[s+1];
    end

    always_comb begin
      div_step_t        st;
      logic [DW-1:0]    w;
      logic [REM_W-1:0] r;
      for (int l = 0; l < DIV_LANES; l++) begin
        w = word_in[l];
        r = rem_in[l];
        for (int t = 0; t < STEPS_PER_STAGE; t++) begin
          st = div_step(r, w[(NDIG - 1 - (s * STEPS_PER_STAGE + t)) * DIG_BITS +: DIG_BITS]);
          w[(NDIG - 1 - (s * STEPS_PER_STAGE + t)) * DIG_BITS +: DIG_BITS] = st.dig;
          r = st.rem;
        end
        word_d[l] = w;
        rem_d[l]  = r;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (rdy[s]) begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[s]) begin
        word_q[s] <= word_d;
        rem_q[s]  <= rem_d;
        side_q[s] <= side_in;
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[NST-1];
  assign out_side_o  = side_q[NST-1];

  for (genvar l = 0; l < DIV_LANES; l++) begin : g_out
    assign out_quo_o[l] = word_q[NST-1][l][IN_W-1:0];
  end

endmodule

// ===== hdl/stereo_width_pan_mix_top.sv =====
// Channel  Handshake             Payload
// cfg      cfg_we_i              cfg_idx_i, cfg_wdata_i
// in       in_valid_i/in_ready_o left_in_i, right_in_i, frame_last_i
// out      out_valid_o/out_ready_i left_out_o, right_out_o, last_out_o
//
// One item per cycle is accepted and delivered in steady flow.
// Each item passes stage A, the stages of the first radix-16 divider by 25, stages B, C
// and D, the stages of the second divider and stage E; a divider takes three digits a stage.
// Reset clears all valid bits and loads the register reset values.
// Every stage holds its item while the stage after it is full and stalled, and empty stages fill.
module stereo_width_pan_mix_top import swpm_pkg::*; #(
  parameter int SAMPLE_BITS    = 24,
  parameter int GAIN_FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]         cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0] left_in_i,
  input  logic signed [SAMPLE_BITS-1:0] right_in_i,
  input  logic                          frame_last_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SAMPLE_BITS-1:0] left_out_o,
  output logic signed [SAMPLE_BITS-1:0] right_out_o,
  output logic                          last_out_o
);

  localparam int SB  = SAMPLE_BITS;
  localparam int GW  = GAIN_FRAC_BITS + 1;
  localparam int PW  = SB + 10;
  localparam int Y1W = SB + 10;
  localparam int UW  = SB + 5;
  localparam int PRW = UW + GW;
  localparam int WTW = SB + 3;
  localparam int N2W = SB + 10;
  localparam int ZW  = N2W - MIX_SHIFT;
  localparam int OW  = SB + 3;

  localparam logic signed [PW-1:0]    HUNDRED  = PW'(PCT_FULL);
  localparam logic [PRW:0]            WET_HALF = (PRW + 1)'(1) << (GAIN_FRAC_BITS + GUARD_BITS - 1);
  localparam logic [N2W-1:0]          MIX_HALF = N2W'(PCT_FULL / 2);
  localparam logic signed [OW-1:0]    SAT_MAX  = OW'({1'b0, {(SB - 1){1'b1}}});
  localparam logic signed [OW-1:0]    SAT_MIN  = ~SAT_MAX;
  localparam logic signed [WTW-1:0]   E_LIM    = WTW'(1) << (SB + 1);
  localparam logic signed [PAN_W-1:0] PAN_MAX  = PAN_W'(PCT_FULL);
  localparam logic signed [PAN_W-1:0] PAN_MIN  = -PAN_MAX;

  typedef struct packed {
    logic                 last;
    logic [1:0]           neg;
    logic [1:0][SB-1:0]   dry;
  } side_t;

  localparam int SIDE_W = $bits(side_t);

  // Configuration registers.
  logic                    enable_q;
  logic                    mono_q;
  logic [MIX_W-1:0]        mix_q;
  logic [WIDTH_W-1:0]      width_q;
  logic signed [PAN_W-1:0] pan_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
      mono_q   <= 1'b0;
      mix_q    <= MIX_W'(PCT_FULL);
      width_q  <= WIDTH_W'(PCT_FULL);
      pan_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ENABLE: enable_q <= cfg_wdata_i[0];
        CFG_MONO:   mono_q   <= cfg_wdata_i[0];
        CFG_MIX:    mix_q    <= cfg_wdata_i[MIX_W-1:0];
        CFG_WIDTH:  width_q  <= cfg_wdata_i[WIDTH_W-1:0];
        CFG_PAN:    pan_q    <= $signed(cfg_wdata_i[PAN_W-1:0]);
        default: ;
      endcase
    end
  end

  logic [MIX_W-1:0]      mix_eff;
  logic [WIDTH_W-1:0]    width_eff;
  logic [GAIN_IDX_W-1:0] idx_l;
  logic [GAIN_IDX_W-1:0] idx_r;

  assign mix_eff   = (mix_q > MIX_W'(PCT_FULL)) ? MIX_W'(PCT_FULL) : mix_q;
  assign width_eff = (width_q > WIDTH_W'(WIDTH_MAX)) ? WIDTH_W'(WIDTH_MAX) : width_q;

  always_comb begin
    priority if (pan_q <= 0) begin
      idx_l = GAIN_IDX_W'(PCT_FULL);
    end else if (pan_q >= PAN_MAX) begin
      idx_l = '0;
    end else begin
      idx_l = GAIN_IDX_W'(PCT_FULL) - pan_q[GAIN_IDX_W-1:0];
    end
    priority if (pan_q >= 0) begin
      idx_r = GAIN_IDX_W'(PCT_FULL);
    end else if (pan_q <= PAN_MIN) begin
      idx_r = '0;
    end else begin
      idx_r = GAIN_IDX_W'(PCT_FULL) + pan_q[GAIN_IDX_W-1:0];
    end
  end

  logic [GW-1:0] gain_rom [GAIN_ENTRIES];
  logic [GW-1:0] gain_q   [DIV_LANES];

  for (genvar k = 0; k < GAIN_ENTRIES; k++) begin : g_gain
    assign gain_rom[k] = GW'(gain_entry(k, GAIN_FRAC_BITS));
  end

  always_ff @(posedge clk_i) begin
    gain_q[0] <= gain_rom[idx_l];
    gain_q[1] <= gain_rom[idx_r];
  end

  // Stage A: mid plus or minus scaled side, before the division by 200.
  logic                 a_vld_q, a_rdy;
  logic signed [PW-1:0] a_p_q [DIV_LANES];
  logic signed [PW-1:0] a_p_d [DIV_LANES];
  side_t                a_side_q;

  always_comb begin
    logic signed [SB:0]   sum_s;
    logic signed [SB:0]   dif_s;
    logic signed [PW-1:0] hund;
    logic signed [PW-1:0] wd;
    sum_s    = $signed({left_in_i[SB-1], left_in_i}) + $signed({right_in_i[SB-1], right_in_i});
    dif_s    = $signed({left_in_i[SB-1], left_in_i}) - $signed({right_in_i[SB-1], right_in_i});
    hund     = PW'(sum_s) * HUNDRED;
    wd       = PW'($signed({1'b0, width_eff})) * PW'(dif_s);
    a_p_d[0] = hund + wd;
    a_p_d[1] = hund - wd;
  end

  // Division one: |u| = floor((2|p| + 12) / 25).
  logic           d1_in_rdy, d1_out_vld;
  logic [Y1W-1:0] y1    [DIV_LANES];
  logic [Y1W-1:0] d1_q  [DIV_LANES];
  logic [PW-1:0]  a_mag [DIV_LANES];
  logic [SIDE_W-1:0] d1_side_v;
  side_t          d1_side;
  side_t          a_side_div;

  assign a_rdy      = !a_vld_q || d1_in_rdy;
  assign in_ready_o = a_rdy;

  always_comb begin
    for (int i = 0; i < DIV_LANES; i++) begin
      a_mag[i] = a_p_q[i][PW-1] ? PW'(-a_p_q[i]) : PW'(a_p_q[i]);
      y1[i]    = {a_mag[i][PW-2:0], 1'b0} + Y1W'(U_BIAS);
    end
    a_side_div     = a_side_q;
    a_side_div.neg = {a_p_q[1][PW-1], a_p_q[0][PW-1]};
  end

  // Stage B: gain product. Stage C: rounded wet value minus dry.
  // Stage D: mix product. Stage E: output register.
  logic                  b_vld_q, b_rdy;
  logic [PRW-1:0]        b_prod_q [DIV_LANES];
  side_t                 b_side_q;
  logic                  c_vld_q, c_rdy;
  logic signed [WTW-1:0] c_e_q [DIV_LANES];
  logic signed [WTW-1:0] c_e_d [DIV_LANES];
  side_t                 c_side_q;
  logic                  d_vld_q, d_rdy;
  logic signed [N2W-1:0] d_n_q [DIV_LANES];
  side_t                 d_side_q;
  logic                  e_vld_q, e_rdy;
  logic signed [SB-1:0]  e_left_q, e_right_q;
  logic                  e_last_q;
  logic                  d2_in_rdy, d2_out_vld;

  assign b_rdy = !b_vld_q || c_rdy;
  assign c_rdy = !c_vld_q || d_rdy;
  assign d_rdy = !d_vld_q || d2_in_rdy;
  assign e_rdy = !e_vld_q || out_ready_i;

  swpm_div25 #(
    .IN_W   (Y1W),
    .SIDE_W (SIDE_W)
  ) u_div_u (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (a_vld_q),
    .in_ready_o  (d1_in_rdy),
    .in_num_i    (y1),
    .in_side_i   (a_side_div),
    .out_valid_o (d1_out_vld),
    .out_ready_i (b_rdy),
    .out_quo_o   (d1_q),
    .out_side_o  (d1_side_v)
  );

  assign d1_side = side_t'(d1_side_v);

  always_comb begin
    logic [PRW:0]          wsum;
    logic [WTW-1:0]        wm;
    logic signed [WTW-1:0] wet;
    for (int i = 0; i < DIV_LANES; i++) begin
      wsum     = (PRW + 1)'(b_prod_q[i]) + WET_HALF;
      wm       = wsum[PRW:GAIN_FRAC_BITS+GUARD_BITS];
      wet      = b_side_q.neg[i] ? -$signed(wm) : $signed(wm);
      c_e_d[i] = wet - WTW'($signed(b_side_q.dry[i]));
    end
  end

  // Division two: |mix term| = floor(((|n| + 50) >> 2) / 25).
  logic [ZW-1:0]     z2   [DIV_LANES];
  logic [ZW-1:0]     d2_q [DIV_LANES];
  logic [SIDE_W-1:0] d2_side_v;
  side_t             d2_side;
  side_t             d_side_div;

  always_comb begin
    logic [N2W-1:0] mag;
    logic [N2W-1:0] bsum;
    for (int i = 0; i < DIV_LANES; i++) begin
      mag   = d_n_q[i][N2W-1] ? N2W'(-d_n_q[i]) : N2W'(d_n_q[i]);
      bsum  = mag + MIX_HALF;
      z2[i] = bsum[N2W-1:MIX_SHIFT];
    end
    d_side_div     = d_side_q;
    d_side_div.neg = {d_n_q[1][N2W-1], d_n_q[0][N2W-1]};
  end

  swpm_div25 #(
    .IN_W   (ZW),
    .SIDE_W (SIDE_W)
  ) u_div_mix (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (d_vld_q),
    .in_ready_o  (d2_in_rdy),
    .in_num_i    (z2),
    .in_side_i   (d_side_div),
    .out_valid_o (d2_out_vld),
    .out_ready_i (e_rdy),
    .out_quo_o   (d2_q),
    .out_side_o  (d2_side_v)
  );

  assign d2_side = side_t'(d2_side_v);

  logic signed [SB-1:0] res_sat [DIV_LANES];
  logic signed [SB-1:0] left_d, right_d;

  always_comb begin
    logic signed [OW-1:0] qs;
    logic signed [OW-1:0] res;
    for (int i = 0; i < DIV_LANES; i++) begin
      qs  = $signed(OW'(d2_q[i][SB+1:0]));
      if (d2_side.neg[i]) begin
        qs = -qs;
      end
      res = OW'($signed(d2_side.dry[i])) + qs;
      priority if (res > SAT_MAX) begin
        res_sat[i] = SAT_MAX[SB-1:0];
      end else if (res < SAT_MIN) begin
        res_sat[i] = SAT_MIN[SB-1:0];
      end else begin
        res_sat[i] = res[SB-1:0];
      end
    end
    priority if (mono_q) begin
      left_d  = $signed(d2_side.dry[0]);
      right_d = '0;
    end else if (!enable_q) begin
      left_d  = $signed(d2_side.dry[0]);
      right_d = $signed(d2_side.dry[1]);
    end else begin
      left_d  = res_sat[0];
      right_d = res_sat[1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
      e_vld_q <= 1'b0;
    end else begin
      if (a_rdy) begin
        a_vld_q <= in_valid_i;
      end
      if (b_rdy) begin
        b_vld_q <= d1_out_vld;
      end
      if (c_rdy) begin
        c_vld_q <= b_vld_q;
      end
      if (d_rdy) begin
        d_vld_q <= c_vld_q;
      end
      if (e_rdy) begin
        e_vld_q <= d2_out_vld;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_rdy) begin
      a_p_q             <= a_p_d;
      a_side_q.dry[0]   <= left_in_i;
      a_side_q.dry[1]   <= right_in_i;
      a_side_q.neg      <= '0;
      a_side_q.last     <= frame_last_i;
    end
    if (b_rdy) begin
      for (int i = 0; i < DIV_LANES; i++) begin
        b_prod_q[i] <= PRW'(d1_q[i][UW-1:0]) * PRW'(gain_q[i]);
      end
      b_side_q <= d1_side;
    end
    if (c_rdy) begin
      c_e_q    <= c_e_d;
      c_side_q <= b_side_q;
    end
    if (d_rdy) begin
      for (int i = 0; i < DIV_LANES; i++) begin
        d_n_q[i] <= N2W'($signed({1'b0, mix_eff})) * N2W'(c_e_q[i]);
      end
      d_side_q <= c_side_q;
    end
    if (e_rdy) begin
      e_left_q  <= left_d;
      e_right_q <= right_d;
      e_last_q  <= d2_side.last;
    end
  end

  assign out_valid_o = e_vld_q;
  assign left_out_o  = e_left_q;
  assign right_out_o = e_right_q;
  assign last_out_o  = e_last_q;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_vld_q && !a_rdy |=> a_vld_q && $stable(a_p_q[0]) && $stable(a_p_q[1]))
    else $error("stage A item changed while stalled");

  e_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    c_vld_q |-> (c_e_q[0] < E_LIM) && (c_e_q[0] > -E_LIM) &&
                (c_e_q[1] < E_LIM) && (c_e_q[1] > -E_LIM))
    else $error("wet minus dry out of range");

  mono_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && mono_q |-> right_out_o == '0)
    else $error("right output not zero in mono mode");

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import swpm_pkg::*;

  localparam int SB          = 24;
  localparam int GAIN_FRAC   = 16;
  localparam int S_MAX       = 8388607;
  localparam int S_MIN       = -8388608;
  localparam int STALL_LIMIT = 4000;
  localparam int PHASE_ITEMS = 64;

  typedef struct packed {
    logic         en;
    logic         mono;
    logic [6:0]   mix;
    logic [7:0]   wid;
    logic [7:0]   pan;
  } settings_t;

  typedef struct packed {
    logic signed [SB-1:0] left;
    logic signed [SB-1:0] right;
    logic                 last;
  } frame_t;

  typedef struct {
    settings_t            cfg;
    logic signed [SB-1:0] left;
    logic signed [SB-1:0] right;
    logic                 last;
    bit                   typed;
    frame_t               want;
  } stim_row_t;

  logic                 clk_i        = 1'b0;
  logic                 rst_ni       = 1'b0;
  logic                 cfg_we_i     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i    = CFG_ENABLE;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                 in_valid_i   = 1'b0;
  logic                 in_ready_o;
  logic signed [SB-1:0] left_in_i    = '0;
  logic signed [SB-1:0] right_in_i   = '0;
  logic                 frame_last_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_ready_i  = 1'b0;
  logic signed [SB-1:0] left_out_o;
  logic signed [SB-1:0] right_out_o;
  logic                 last_out_o;

  settings_t  active_cfg = '{en: 1'b0, mono: 1'b0, mix: 7'd100, wid: 8'd100, pan: 8'd0};
  longint     gain_lut [0:100];
  frame_t     expected_frames [$];
  stim_row_t  directed_rows [$];
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  int         errors        = 0;
  int         stall_cycles  = 0;

  stereo_width_pan_mix_top u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .left_in_i    (left_in_i),
    .right_in_i   (right_in_i),
    .frame_last_i (frame_last_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .left_out_o   (left_out_o),
    .right_out_o  (right_out_o),
    .last_out_o   (last_out_o)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  function automatic longint root_floor(longint v);
    longint res;
    longint t;
    res = 0;
    for (int b = 20; b >= 0; b--) begin
      t = res | (longint'(1) << b);
      if (t * t <= v) res = t;
    end
    return res;
  endfunction

  function automatic longint round_div(longint n, longint d);
    longint mag;
    longint q;
    mag = (n < 0) ? -n : n;
    q   = (mag + d / 2) / d;
    return (n < 0) ? -q : q;
  endfunction

  function automatic int pct_index(longint k);
    if (k < 0) return 0;
    if (k > 100) return 100;
    return int'(k);
  endfunction

  function automatic logic signed [SB-1:0] wet_channel(longint p, longint g, longint dry,
                                                        longint m);
    longint u;
    longint wet;
    longint o;
    u   = round_div(p * 16, 200);
    wet = round_div(u * g, longint'(1) << (GAIN_FRAC + 4));
    o   = dry + round_div(m * (wet - dry), 100);
    if (o > S_MAX) o = S_MAX;
    if (o < S_MIN) o = S_MIN;
    return SB'(o);
  endfunction

  function automatic frame_t mix_frame(settings_t s, logic signed [SB-1:0] l,
                                       logic signed [SB-1:0] r, logic last);
    frame_t res;
    longint lv, rv, m, w, p, sum, dif;
    lv       = l;
    rv       = r;
    res.last = last;
    if (s.mono) begin
      res.left  = l;
      res.right = '0;
    end else if (!s.en) begin
      res.left  = l;
      res.right = r;
    end else begin
      m   = (s.mix > 7'd100) ? 100 : longint'(s.mix);
      w   = (s.wid > 8'd200) ? 200 : longint'(s.wid);
      p   = longint'(signed'(s.pan));
      sum = lv + rv;
      dif = lv - rv;
      res.left  = wet_channel(100 * sum + w * dif, gain_lut[pct_index(100 - p)], lv, m);
      res.right = wet_channel(100 * sum - w * dif, gain_lut[pct_index(100 + p)], rv, m);
    end
    return res;
  endfunction

  function automatic void add_row(int en, int mono, int mix, int wid, int pan, int l, int r,
                                  int last, bit typed, int el, int er);
    stim_row_t row;
    row.cfg        = '{en: 1'(en), mono: 1'(mono), mix: 7'(mix), wid: 8'(wid), pan: 8'(pan)};
    row.left       = SB'(l);
    row.right      = SB'(r);
    row.last       = 1'(last);
    row.typed      = typed;
    row.want.left  = SB'(el);
    row.want.right = SB'(er);
    row.want.last  = 1'(last);
    directed_rows.push_back(row);
  endfunction

  function automatic logic signed [SB-1:0] rand_sample();
    case ($urandom_range(7))
      0: return SB'(S_MAX);
      1: return SB'(S_MIN);
      2: return SB'(int'($urandom_range(64)) - 32);
      default: return SB'($urandom);
    endcase
  endfunction

  function automatic settings_t rand_settings();
    settings_t s;
    s.en   = ($urandom_range(9) != 0);
    s.mono = ($urandom_range(9) == 0);
    case ($urandom_range(5))
      0: s.mix = 7'd0;
      1: s.mix = 7'd100;
      2: s.mix = 7'($urandom_range(127, 101));
      default: s.mix = 7'($urandom_range(100));
    endcase
    case ($urandom_range(5))
      0: s.wid = 8'd0;
      1: s.wid = 8'd200;
      2: s.wid = 8'($urandom_range(255, 201));
      default: s.wid = 8'($urandom_range(200));
    endcase
    case ($urandom_range(5))
      0: s.pan = 8'(-100);
      1: s.pan = 8'd100;
      2: s.pan = 8'($urandom_range(255));
      default: s.pan = 8'(int'($urandom_range(200)) - 100);
    endcase
    return s;
  endfunction

  function automatic void check_field(string name, logic signed [31:0] want_v,
                                      logic signed [31:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want_v, got_v);
      errors++;
    end
  endfunction

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
  endtask

  task automatic apply_settings(settings_t s);
    write_reg(CFG_ENABLE, CFG_DATA_W'(s.en));
    write_reg(CFG_MONO, CFG_DATA_W'(s.mono));
    write_reg(CFG_MIX, CFG_DATA_W'(s.mix));
    write_reg(CFG_WIDTH, CFG_DATA_W'(s.wid));
    write_reg(CFG_PAN, CFG_DATA_W'(s.pan));
    cfg_we_i   <= 1'b0;
    active_cfg = s;
    @(negedge clk_i);
  endtask

  task automatic drain_pipeline();
    in_valid_i <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_frame(logic signed [SB-1:0] l, logic signed [SB-1:0] r, logic last,
                            bit typed, frame_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    left_in_i    <= l;
    right_in_i   <= r;
    frame_last_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    expected_frames.push_back(typed ? want : mix_frame(active_cfg, l, r, last));
    @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    frame_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_frames.size() == 0) begin
        $display("%0t: unexpected item expected none got left %0d right %0d last %0d",
                 $time, left_out_o, right_out_o, last_out_o);
        errors++;
      end else begin
        want = expected_frames.pop_front();
        check_field("left_out", want.left, left_out_o);
        check_field("right_out", want.right, right_out_o);
        check_field("last_out", {31'd0, want.last}, {31'd0, last_out_o});
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    settings_t s;
    frame_t    none;
    none = '0;
    for (int k = 0; k <= 100; k++) begin
      gain_lut[k] = (root_floor((longint'(k) << (2 * GAIN_FRAC + 2)) / 100) + 1) >> 1;
    end

    add_row(0, 0, 100, 100, 0, S_MAX, S_MIN, 1, 1, S_MAX, S_MIN);
    add_row(0, 0, 100, 100, 0, 0, -1, 0, 1, 0, -1);
    add_row(0, 1, 100, 100, 0, 'h123456, S_MAX, 1, 1, 'h123456, 0);
    add_row(1, 1, 100, 100, 0, S_MIN, 5, 0, 1, S_MIN, 0);
    add_row(1, 0, 100, 100, 0, S_MAX, S_MIN, 1, 1, S_MAX, S_MIN);
    add_row(1, 0, 100, 100, 0, 1, -3, 0, 1, 1, -3);
    add_row(1, 0, 100, 200, 0, S_MAX, S_MIN, 0, 1, S_MAX, S_MIN);
    add_row(1, 0, 100, 200, 0, S_MIN, S_MAX, 1, 1, S_MIN, S_MAX);
    add_row(1, 0, 0, 200, 37, 'h2AAAAA, -'h155555, 0, 1, 'h2AAAAA, -'h155555);
    add_row(1, 0, 100, 100, -100, 'h400000, 'h300000, 1, 1, 'h400000, 0);
    add_row(1, 0, 100, 100, 100, 'h400000, -'h300000, 0, 1, 0, -'h300000);
    add_row(1, 0, 100, 100, -128, -'h12345, 'h54321, 1, 1, -'h12345, 0);
    add_row(1, 0, 100, 100, 127, -'h12345, 'h54321, 0, 1, 0, 'h54321);
    add_row(1, 0, 127, 255, 0, S_MAX, 0, 1, 0, 0, 0);
    add_row(1, 0, 101, 201, -25, -7, 4, 0, 0, 0, 0);
    add_row(1, 0, 50, 0, 0, 3, 0, 1, 0, 0, 0);
    add_row(1, 0, 50, 0, 0, -3, 0, 0, 0, 0, 0);
    add_row(1, 0, 1, 150, 60, S_MIN, S_MIN, 1, 0, 0, 0);
    add_row(1, 0, 99, 1, -99, 'h7FFFF0, -16, 0, 0, 0, 0);
    add_row(0, 0, 37, 80, 20, S_MIN, S_MAX, 1, 1, S_MIN, S_MAX);

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_idle_pct = 37;
    recv_idle_pct = 52;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].cfg != active_cfg) begin
        drain_pipeline();
        apply_settings(directed_rows[i].cfg);
      end
      send_frame(directed_rows[i].left, directed_rows[i].right, directed_rows[i].last,
                 directed_rows[i].typed, directed_rows[i].want);
    end

    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 37 : (mode == 1) ? 52 : 0;
      recv_idle_pct = (mode == 0) ? 52 : (mode == 1) ? 37 : 0;
      for (int ph = 0; ph < 6; ph++) begin
        s = rand_settings();
        if (ph == 0) begin
          case (mode)
            0: s = '{en: 1'b1, mono: 1'b0, mix: 7'd100, wid: 8'd200, pan: 8'(-100)};
            1: s = '{en: 1'b1, mono: 1'b0, mix: 7'd127, wid: 8'd255, pan: 8'h7F};
            default: s = '{en: 1'b1, mono: 1'b0, mix: 7'd0, wid: 8'd0, pan: 8'h80};
          endcase
        end
        drain_pipeline();
        apply_settings(s);
        repeat (PHASE_ITEMS) begin
          send_frame(rand_sample(), rand_sample(), 1'($urandom_range(1)), 1'b0, none);
        end
      end
    end

    drain_pipeline();
    repeat (24) @(posedge clk_i);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
